FILE: design/lebr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lebr_pkg: shared types and constants of the light event burst relay
// Codes for operations, node roles and configuration registers, and the
// structs that carry configuration and pending output work between modules.
// ----------------------------------------------------------------------------
package lebr_pkg;

    // Largest number of packets sent for one light change.
    localparam int MAX_BURST = 8;

    // Widths fixed by the info byte layout.
    localparam int PID_W   = 3;
    localparam int BURST_W = 4;

    // Operation codes of an input item. Code 3 is ignored.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_BEACON = 2'd2;

    // Node roles. Role code 3 behaves as a relay.
    localparam logic [1:0] ROLE_RELAY  = 2'd0;
    localparam logic [1:0] ROLE_SENSOR = 2'd1;
    localparam logic [1:0] ROLE_SINK   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NODE_ROLE      = 3'd0;
    localparam logic [2:0] CFG_SENSOR_PRESENT = 3'd1;
    localparam logic [2:0] CFG_LUX_CENTER     = 3'd2;
    localparam logic [2:0] CFG_LUX_BAND       = 3'd3;
    localparam logic [2:0] CFG_BURST_SIZE     = 3'd4;

    typedef struct packed {
        logic [1:0]  node_role;
        logic        sensor_present;
        logic [15:0] lux_center;
        logic [14:0] lux_band;
        logic [3:0]  burst_size;
    } cfg_t;

    // Output work left behind by one input item: a run of packet ids from
    // first_pid to last_pid, all sharing the same burst and light state.
    typedef struct packed {
        logic               send;
        logic [BURST_W-1:0] burst;
        logic [PID_W-1:0]   first_pid;
        logic [PID_W-1:0]   last_pid;
        logic               light_on;
    } job_t;

endpackage
`default_nettype wire

FILE: design/lebr_node.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lebr_node: node state and per-item decision
// Holds light state, burst id and the seen packet map, and turns one input
// item into the output work it causes. State advances when an item is taken.
// ----------------------------------------------------------------------------
module lebr_node (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         take,
    input  wire lebr_pkg::cfg_t cfg,
    input  wire logic [1:0]   op,
    input  wire logic [15:0]  lux_reading,
    input  wire logic [7:0]   info_in,
    input  wire logic         synced,
    output lebr_pkg::job_t    job
);
    import lebr_pkg::*;

    logic               light_state_reg, light_state_next;
    logic [BURST_W-1:0] burst_id_reg, burst_id_next;
    logic [7:0]         seen_map_reg, seen_map_next;

    logic [16:0]        on_bound;
    logic [16:0]        lux_plus_hys;
    logic               turn_on, turn_off;
    logic [BURST_W-1:0] pkt_burst, burst_diff;
    logic [PID_W-1:0]   pkt_pid;
    logic               pkt_state;
    logic               burst_ok, burst_newer;
    logic [7:0]         eff_map;
    logic [3:0]         size;

    always_comb
    begin
        // Bounds are taken at 17 bits so they never wrap. The turn-off test
        // lux < thr - hys is rewritten as lux + hys < thr.
        on_bound     = {1'b0, cfg.lux_center} + {2'b00, cfg.lux_band};
        lux_plus_hys = {1'b0, lux_reading} + {2'b00, cfg.lux_band};
        turn_on      = !light_state_reg && ({1'b0, lux_reading} >= on_bound);
        turn_off     = light_state_reg && (lux_plus_hys < {1'b0, cfg.lux_center});

        pkt_burst   = info_in[7:4];
        pkt_pid     = info_in[3:1];
        pkt_state   = info_in[0];
        burst_diff  = pkt_burst - burst_id_reg;
        burst_ok    = !burst_diff[BURST_W-1];
        burst_newer = burst_ok && (pkt_burst != burst_id_reg);
        eff_map     = burst_newer ? 8'h00 : seen_map_reg;

        if (cfg.burst_size == 4'd0)
        begin
            size = 4'd1;
        end
        else if (cfg.burst_size > 4'(MAX_BURST))
        begin
            size = 4'(MAX_BURST);
        end
        else
        begin
            size = cfg.burst_size;
        end

        light_state_next = light_state_reg;
        burst_id_next    = burst_id_reg;
        seen_map_next    = seen_map_reg;
        job.send         = 1'b0;
        job.burst        = '0;
        job.first_pid    = '0;
        job.last_pid     = '0;

        case (op)
            OP_SAMPLE:
            begin
                if ((cfg.node_role == ROLE_SENSOR) && cfg.sensor_present &&
                    (turn_on || turn_off))
                begin
                    light_state_next = !light_state_reg;
                    burst_id_next    = burst_id_reg + 4'd1;
                    job.send         = 1'b1;
                    job.burst        = burst_id_reg + 4'd1;
                    job.last_pid     = PID_W'(size - 4'd1);
                end
            end
            OP_DATA:
            begin
                if (synced && (cfg.node_role != ROLE_SENSOR) && burst_ok &&
                    !eff_map[pkt_pid])
                begin
                    seen_map_next    = eff_map | (8'h01 << pkt_pid);
                    burst_id_next    = pkt_burst;
                    light_state_next = pkt_state;
                    if (cfg.node_role != ROLE_SINK)
                    begin
                        job.send      = 1'b1;
                        job.burst     = pkt_burst;
                        job.first_pid = pkt_pid;
                        job.last_pid  = pkt_pid;
                    end
                end
            end
            OP_BEACON:
            begin
                if (burst_ok)
                begin
                    seen_map_next    = eff_map;
                    burst_id_next    = pkt_burst;
                    light_state_next = pkt_state;
                end
            end
            default:
            begin
            end
        endcase

        job.light_on = light_state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_state_reg <= 1'b0;
            burst_id_reg    <= '0;
            seen_map_reg    <= '0;
        end
        else if (take)
        begin
            light_state_reg <= light_state_next;
            burst_id_reg    <= burst_id_next;
            seen_map_reg    <= seen_map_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/light_event_burst_relay_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// light_event_burst_relay_core: event flood node for light on/off events
// Decides on light samples, data packets and beacons, and emits the packet
// info bytes of a burst or a relayed packet one result per cycle while out_ready is high.
// ----------------------------------------------------------------------------
// An item is taken into a one-entry holding register in the cycle it is
// offered if that register is free or empties in the same cycle, and node
// state (light state, burst id, seen map) is updated at that moment, so the
// next item sees it at once. From the holding register the item's work moves
// to the output register, which shows one result per cycle while out_ready is
// high. Items that give one result (a relayed packet or nothing to send)
// therefore flow at one per cycle; a light change gives burst_size results
// (clamped to 1..8) and holds the output register until its last result is
// taken, which holds up the items behind it. An item with nothing to send
// still gives one result with send low and info_out zero. Configuration
// writes are always ready and should be made only while the block is idle.
// ----------------------------------------------------------------------------
module light_event_burst_relay_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] lux_reading,
    input  wire logic [7:0]  info_in,
    input  wire logic        synced,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             send,
    output logic [7:0]       info_out,
    output logic             light_on,
    output logic             last
);
    import lebr_pkg::*;

    // Configuration registers.
    cfg_t cfg_reg;

    // Holding register between the decision logic and the output register.
    logic pend_valid_reg, pend_valid_next;
    job_t pend_job_reg;
    job_t new_job;

    // Output register: the work being shown and the current packet id.
    logic             out_valid_reg, out_valid_next;
    job_t             cur_job_reg, cur_job_next;
    logic [PID_W-1:0] pid_reg, pid_next;

    logic in_accept;
    logic out_accept;
    logic cur_last;
    logic out_free;
    logic move;

    // Configuration writes never stall.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_role      <= ROLE_RELAY;
            cfg_reg.sensor_present <= 1'b0;
            cfg_reg.lux_center     <= 16'd1000;
            cfg_reg.lux_band       <= 15'd100;
            cfg_reg.burst_size     <= 4'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NODE_ROLE:      cfg_reg.node_role      <= cfg_data[1:0];
                CFG_SENSOR_PRESENT: cfg_reg.sensor_present <= cfg_data[0];
                CFG_LUX_CENTER:     cfg_reg.lux_center     <= cfg_data;
                CFG_LUX_BAND:       cfg_reg.lux_band       <= cfg_data[14:0];
                CFG_BURST_SIZE:     cfg_reg.burst_size     <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Decision logic and node state.
    lebr_node u_node (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (in_accept),
        .cfg         (cfg_reg),
        .op          (op),
        .lux_reading (lux_reading),
        .info_in     (info_in),
        .synced      (synced),
        .job         (new_job)
    );

    // The output register frees up when it is empty or its final result is
    // taken; the holding register then hands its work over in the same cycle.
    always_comb
    begin
        cur_last   = (pid_reg == cur_job_reg.last_pid);
        out_accept = out_valid_reg && out_ready;
        out_free   = !out_valid_reg || (out_ready && cur_last);
        move       = pend_valid_reg && out_free;
        in_ready   = !pend_valid_reg || move;
        in_accept  = in_valid && in_ready;

        pend_valid_next = in_accept || (pend_valid_reg && !move);

        out_valid_next = out_valid_reg;
        cur_job_next   = cur_job_reg;
        pid_next       = pid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
            cur_job_next   = pend_job_reg;
            pid_next       = pend_job_reg.first_pid;
        end
        else if (out_accept)
        begin
            if (cur_last)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                pid_next = pid_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pend_job_reg <= new_job;
        end
        cur_job_reg <= cur_job_next;
        pid_reg     <= pid_next;
    end

    // A result with nothing to send carries an all-zero info byte.
    assign out_valid = out_valid_reg;
    assign send      = cur_job_reg.send;
    assign info_out  = cur_job_reg.send ?
                       {cur_job_reg.burst, pid_reg, cur_job_reg.light_on} : 8'h00;
    assign light_on  = cur_job_reg.light_on;
    assign last      = cur_last;

    // The packet id never runs past the end of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pid_reg <= cur_job_reg.last_pid))
    else $error("packet id ran past the end of its burst");

    // An item with nothing to send gives exactly one result, with a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !send) |-> (last && (info_out == 8'h00)))
    else $error("non-sending result is not a single zero result");

    // A burst that is not finished keeps the output register busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
    else $error("output dropped in the middle of a burst");

    // Work waiting in the holding register blocks new items until it moves.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && out_valid_reg && !(out_ready && cur_last)) |-> !in_ready)
    else $error("item taken while holding register stays full");

endmodule
`default_nettype wire
